[rtl/dpt_pkg.sv]
// ----------------------------------------------------------------------------
// Direct peer table package
// Shared constants, codes and types of the direct peer table.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

	localparam int PEER_SLOTS = 32;
	localparam int NODE_SLOTS = 16;
	localparam int SLOT_W = $clog2(PEER_SLOTS);
	localparam int NODE_IDX_W = $clog2(NODE_SLOTS);
	localparam int NODE_W = 5;
	localparam int CNT_W = 6;
	localparam int ANN_W = 16;
	localparam int PADDR_W = 3;

	localparam logic [31:0] LIFETIME_RESET = 32'd86400;
	localparam logic [ANN_W-1:0] ANN_MAX = '1;
	localparam logic [NODE_W-1:0] NODE_UNKNOWN = '1;
	localparam logic [PADDR_W-1:0] ADDR_LIFETIME = 3'd0;

	// Request selector codes.
	localparam logic [1:0] FUNC_ANNOUNCE = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_GONE = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_REPLACED = 3'd2;
	localparam logic [2:0] ST_UPLINK = 3'd3;
	localparam logic [2:0] ST_FWD_MARKED = 3'd4;
	localparam logic [2:0] ST_FWD_SAME = 3'd5;
	localparam logic [2:0] ST_MAINT = 3'd6;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] iface_id;
		logic [63:0] dest_high;
		logic [63:0] dest_low;
		logic signed [NODE_W-1:0] node_slot;
		logic [7:0] hop_count;
		logic [7:0] radius;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [SLOT_W-1:0] slot;
		logic [ANN_W-1:0] announce_total;
		logic [CNT_W-1:0] node_peers;
		logic [CNT_W-1:0] removed_count;
	} out_item_t;

	// One stored peer entry.
	typedef struct packed {
		logic [7:0] iface;
		logic [63:0] dest_high;
		logic [63:0] dest_low;
		logic [31:0] heard;
		logic [NODE_W-1:0] node;
		logic [ANN_W-1:0] announces;
	} peer_entry_t;

	localparam int ENTRY_W = $bits(peer_entry_t);

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic finish;
	} dpt_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic need_scan;
		logic out_free;
	} dpt_sts_t;

endpackage

`default_nettype wire

[rtl/dpt_req_if.sv]
// ----------------------------------------------------------------------------
// Direct peer table request channel
// Valid/ready channel that carries one request to the table.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpt_req_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [7:0] iface_id;
	logic [63:0] dest_high;
	logic [63:0] dest_low;
	logic signed [4:0] node_slot;
	logic [7:0] hop_count;
	logic [7:0] radius;
	logic signal_valid;
	logic signed [15:0] rssi_dbm;
	logic signed [15:0] snr_tenths;
	logic [31:0] now_seconds;

	modport source (output valid, func, iface_id, dest_high, dest_low, node_slot,
		hop_count, radius, signal_valid, rssi_dbm, snr_tenths, now_seconds,
		input ready);
	modport sink (input valid, func, iface_id, dest_high, dest_low, node_slot,
		hop_count, radius, signal_valid, rssi_dbm, snr_tenths, now_seconds,
		output ready);
endinterface

`default_nettype wire

[rtl/dpt_rsp_if.sv]
// ----------------------------------------------------------------------------
// Direct peer table result channel
// Valid/ready channel that carries one result from the table.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpt_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [4:0] slot;
	logic [15:0] announce_total;
	logic [5:0] node_peers;
	logic [5:0] removed_count;

	modport source (output valid, status, slot, announce_total, node_peers,
		removed_count, input ready);
	modport sink (input valid, status, slot, announce_total, node_peers,
		removed_count, output ready);
endinterface

`default_nettype wire

[rtl/direct_peer_table_top.sv]
// ----------------------------------------------------------------------------
// Direct peer table
// Table of one-hop peers keyed by interface and destination, with ageing.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake         Carries
//  req       in         valid/ready       announce, tick or interface-gone request
//  rsp       out        valid/ready       one result per request
//  apb       in         psel/penable      peer_lifetime register at address 0
//
// A scanning request goes from acceptance to result through a decode state,
// a read of every slot through the single read port of the peer RAM, a drain
// state for the registered read data and a commit state. Other requests go
// from decode straight to commit. One request is handled at a time; a new
// one is accepted while the last result waits. The result stage holds under
// a stalled consumer. Reset clears all valid bits and forwarder flags at once.
`default_nettype none

module direct_peer_table_top (
	input wire logic clk,
	input wire logic arst_n,
	dpt_req_if.sink req,
	dpt_rsp_if.source rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [dpt_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import dpt_pkg::*;

	logic [31:0] lifetime_q;
	dpt_cmd_t cmd;
	dpt_sts_t sts;
	in_item_t in_item;
	out_item_t out_item;

	// Register port.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_LIFETIME) ? lifetime_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_LIFETIME)) begin
			lifetime_q <= pwdata;
		end
	end

	// Request fields that the table uses.
	always_comb begin
		in_item.func = req.func;
		in_item.iface_id = req.iface_id;
		in_item.dest_high = req.dest_high;
		in_item.dest_low = req.dest_low;
		in_item.node_slot = req.node_slot;
		in_item.hop_count = req.hop_count;
		in_item.radius = req.radius;
		in_item.now_seconds = req.now_seconds;
	end

	dpt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.cmd(cmd),
		.sts(sts)
	);

	dpt_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_item(in_item),
		.lifetime(lifetime_q),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_item(out_item)
	);

	assign rsp.status = out_item.status;
	assign rsp.slot = out_item.slot;
	assign rsp.announce_total = out_item.announce_total;
	assign rsp.node_peers = out_item.node_peers;
	assign rsp.removed_count = out_item.removed_count;

endmodule

`default_nettype wire

[rtl/dpt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/dpt_ctrl.sv]
// ----------------------------------------------------------------------------
// Direct peer table controller
// Sequences decode, the table scan and completion of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	output dpt_pkg::dpt_cmd_t cmd,
	input wire dpt_pkg::dpt_sts_t sts
);
	import dpt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic [SLOT_W-1:0] addr_q;

	assign req_ready = (state_q == S_IDLE);

	// Commands follow the state.
	always_comb begin
		cmd.load = req_valid && (state_q == S_IDLE);
		cmd.rd_en = (state_q == S_SCAN);
		cmd.rd_addr = addr_q;
		cmd.finish = (state_q == S_FINISH) && sts.out_free;
	end

	// State and scan address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					addr_q <= '0;
					state_q <= sts.need_scan ? S_SCAN : S_FINISH;
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == SLOT_W'(PEER_SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/dpt_datapath.sv]
// ----------------------------------------------------------------------------
// Direct peer table datapath
// Holds the request, the peer store, the scan trackers and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire dpt_pkg::dpt_cmd_t cmd,
	output dpt_pkg::dpt_sts_t sts,
	input wire dpt_pkg::in_item_t in_item,
	input wire logic [31:0] lifetime,
	output logic out_valid,
	input wire logic out_ready,
	output dpt_pkg::out_item_t out_item
);
	import dpt_pkg::*;

	// Latched request.
	logic [1:0] func_q;
	logic [7:0] iface_q;
	logic [63:0] dh_q;
	logic [63:0] dl_q;
	logic [NODE_W-1:0] node_q;
	logic node_ok_q;
	logic [7:0] hops_q;
	logic [7:0] radius_q;
	logic [31:0] now_q;

	// Peer valid bits and node forwarder flags.
	logic [PEER_SLOTS-1:0] valid_q;
	logic [NODE_SLOTS-1:0] fwd_q;

	// Scan read pipeline.
	logic rd_v_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [ENTRY_W-1:0] rdata;
	peer_entry_t ent;

	// Scan trackers.
	logic match_q, free_q, old_q;
	logic [SLOT_W-1:0] match_idx_q, free_idx_q, old_idx_q;
	logic [ANN_W-1:0] match_ann_q;
	logic match_neq_q, old_neq_q;
	logic [31:0] old_heard_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] removed_q;

	// Finish stage.
	logic out_valid_q;
	out_item_t out_q;
	out_item_t res_d;
	logic mark_fwd;
	logic is_direct;
	logic we;
	logic [SLOT_W-1:0] wslot;
	peer_entry_t wentry;
	logic [ANN_W-1:0] ann_new;
	logic [2:0] ann_status;
	logic sub_one;

	logic ent_v, ent_key, ent_neq, ent_aged;

	assign ent = peer_entry_t'(rdata);
	assign is_direct = (hops_q <= 8'd1) && (radius_q != 8'd0);

	assign sts.need_scan = ((func_q == FUNC_ANNOUNCE) && is_direct) ||
		(func_q == FUNC_TICK) || (func_q == FUNC_GONE);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// Per-entry tests on the read data.
	always_comb begin
		ent_v = valid_q[idx_s1];
		ent_key = (ent.iface == iface_q) && (ent.dest_high == dh_q) &&
			(ent.dest_low == dl_q);
		ent_neq = node_ok_q && (ent.node == node_q);
		ent_aged = (now_q > ent.heard) && ((now_q - ent.heard) > lifetime);
	end

	// Target slot and new entry of a direct announce.
	always_comb begin
		if (match_q) begin
			wslot = match_idx_q;
			ann_status = ST_UPDATED;
			ann_new = (match_ann_q == ANN_MAX) ? match_ann_q : match_ann_q + 1'b1;
			sub_one = match_neq_q;
		end else if (free_q) begin
			wslot = free_idx_q;
			ann_status = ST_INSERTED;
			ann_new = ANN_W'(1);
			sub_one = 1'b0;
		end else begin
			wslot = old_idx_q;
			ann_status = ST_REPLACED;
			ann_new = ANN_W'(1);
			sub_one = old_neq_q;
		end
		wentry.iface = iface_q;
		wentry.dest_high = dh_q;
		wentry.dest_low = dl_q;
		wentry.heard = now_q;
		wentry.node = node_q;
		wentry.announces = ann_new;
		we = cmd.finish && (func_q == FUNC_ANNOUNCE) && is_direct;
	end

	// Result of the request and the forwarder flag to set.
	always_comb begin
		res_d = '0;
		res_d.status = ST_MAINT;
		mark_fwd = 1'b0;
		if (func_q == FUNC_ANNOUNCE) begin
			if (hops_q > 8'd1) begin
				res_d.status = ST_FWD_SAME;
				if (node_ok_q && !fwd_q[node_q[NODE_IDX_W-1:0]]) begin
					mark_fwd = 1'b1;
					res_d.status = ST_FWD_MARKED;
				end
			end else if (radius_q == 8'd0) begin
				res_d.status = ST_UPLINK;
			end else begin
				res_d.status = ann_status;
				res_d.slot = wslot;
				res_d.announce_total = ann_new;
				res_d.node_peers = node_ok_q ? cnt_q - CNT_W'(sub_one) + 1'b1 : '0;
			end
		end else if ((func_q == FUNC_TICK) || (func_q == FUNC_GONE)) begin
			res_d.removed_count = removed_q;
		end
	end

	dpt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PEER_SLOTS)
	) u_peer_ram (
		.clk(clk),
		.we(we),
		.waddr(wslot),
		.wdata(wentry),
		.raddr(cmd.rd_addr),
		.rdata(rdata)
	);

	// Request latch; payload needs no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_item.func;
			iface_q <= in_item.iface_id;
			dh_q <= in_item.dest_high;
			dl_q <= in_item.dest_low;
			node_ok_q <= (unsigned'(in_item.node_slot) < NODE_W'(NODE_SLOTS));
			node_q <= (unsigned'(in_item.node_slot) < NODE_W'(NODE_SLOTS)) ?
				unsigned'(in_item.node_slot) : NODE_UNKNOWN;
			hops_q <= in_item.hop_count;
			radius_q <= in_item.radius;
			now_q <= in_item.now_seconds;
		end
		idx_s1 <= cmd.rd_addr;
	end

	// Control state: valid bits, flags, trackers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fwd_q <= '0;
			rd_v_s1 <= 1'b0;
			match_q <= 1'b0;
			free_q <= 1'b0;
			old_q <= 1'b0;
			match_idx_q <= '0;
			free_idx_q <= '0;
			old_idx_q <= '0;
			match_ann_q <= '0;
			match_neq_q <= 1'b0;
			old_neq_q <= 1'b0;
			old_heard_q <= '0;
			cnt_q <= '0;
			removed_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			rd_v_s1 <= cmd.rd_en;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				match_q <= 1'b0;
				free_q <= 1'b0;
				old_q <= 1'b0;
				cnt_q <= '0;
				removed_q <= '0;
			end
			// One entry per cycle during the scan.
			if (rd_v_s1) begin
				case (func_q)
					FUNC_ANNOUNCE: begin
						if (!ent_v) begin
							if (!free_q) begin
								free_q <= 1'b1;
								free_idx_q <= idx_s1;
							end
						end else begin
							if (ent_neq) begin
								cnt_q <= cnt_q + 1'b1;
							end
							if (!match_q) begin
								if (ent_key) begin
									match_q <= 1'b1;
									match_idx_q <= idx_s1;
									match_ann_q <= ent.announces;
									match_neq_q <= ent_neq;
								end else if (!old_q || (ent.heard < old_heard_q)) begin
									old_q <= 1'b1;
									old_idx_q <= idx_s1;
									old_heard_q <= ent.heard;
									old_neq_q <= ent_neq;
								end
							end
						end
					end
					FUNC_TICK: begin
						if (ent_v && ent_aged) begin
							valid_q[idx_s1] <= 1'b0;
							removed_q <= removed_q + 1'b1;
						end
					end
					FUNC_GONE: begin
						if (ent_v && (ent.iface == iface_q)) begin
							valid_q[idx_s1] <= 1'b0;
							removed_q <= removed_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			// Completion: commit the entry and load the result.
			if (cmd.finish) begin
				out_q <= res_d;
				if (mark_fwd) begin
					fwd_q[node_q[NODE_IDX_W-1:0]] <= 1'b1;
				end
				if (we) begin
					valid_q[wslot] <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire
